// File: src/sha256_pkg.sv
// Shared SHA-256 constants, round-constant lookup and controller command types.
// No dependencies; compiled first.
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW = 32;

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_LOAD  = 3'd2,
    CMD_ROUND = 3'd3,
    CMD_ADD   = 3'd4,
    CMD_INIT  = 3'd5
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic [7:0] push_byte;
    logic [5:0] round;
    logic [2:0] out_sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [63:0] byte_count;
  } dp_stat_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

endpackage
`default_nettype wire

// File: src/sha256_if.sv
// Valid/ready channel interfaces for the byte input and the digest output.
// Depends on nothing.
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: src/sha256_dp.sv
// SHA-256 datapath: block buffer, rolling schedule, round unit, chaining hash.
// Depends on sha256_pkg.
`default_nettype none
module sha256_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  sha256_pkg::dp_ctrl_t  ctrl_i,
  output sha256_pkg::dp_stat_t  stat_o,
  output logic [31:0]           hash_word_o
);
  import sha256_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q;
  logic [63:0] cnt_q;

  logic [3:0]  pos_w;
  logic [4:0]  sh;
  logic [31:0] x15, x2, s0, s1, wnew, wr, e, a, t1, t2;
  logic [3:0]  r4;

  assign pos_w = fill_q[5:2];
  assign sh    = 5'd24 - {fill_q[1:0], 3'b000};
  assign r4    = ctrl_i.round[3:0];

  // Schedule word for this round
  assign x15  = w_q[r4 + 4'd1];
  assign x2   = w_q[r4 + 4'd14];
  assign s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
  assign s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
  assign wnew = w_q[r4] + s0 + w_q[r4 + 4'd9] + s1;
  assign wr   = (ctrl_i.round < 6'd16) ? w_q[r4] : wnew;

  // Round function
  assign e  = v_q[4];
  assign a  = v_q[0];
  assign t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(ctrl_i.round) + wr;
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  // Hold schedule and working words
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_PUSH: begin
        if (fill_q[1:0] == 2'd0) w_q[pos_w] <= {24'd0, ctrl_i.push_byte} << sh;
        else w_q[pos_w] <= w_q[pos_w] | ({24'd0, ctrl_i.push_byte} << sh);
      end
      CMD_LOAD: v_q <= h_q;
      CMD_ROUND: begin
        if (ctrl_i.round >= 6'd16) w_q[r4] <= wnew;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= e; v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= a; v_q[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  // Advance fill, count and chaining hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      unique case (ctrl_i.cmd)
        CMD_PUSH: fill_q <= fill_q + 6'd1;
        CMD_ADD:  for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        CMD_INIT: begin
          fill_q <= '0;
          cnt_q  <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
        end
        default: ;
      endcase
      if (ctrl_i.cmd == CMD_PUSH && ctrl_i.round == 6'd1) cnt_q <= cnt_q + 64'd1;
    end
  end

  assign stat_o.fill       = fill_q;
  assign stat_o.byte_count = cnt_q;
  assign hash_word_o       = h_q[ctrl_i.out_sel];

endmodule
`default_nettype wire

// File: src/sha256_ctrl.sv
// SHA-256 controller: input handshake, padding sequence, rounds, digest output.
// Depends on sha256_pkg and sha256_if.
`default_nettype none
module sha256_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  sha256_in_if.sink             in_if,
  sha256_out_if.source          out_if,
  output sha256_pkg::dp_ctrl_t  ctrl_o,
  input  sha256_pkg::dp_stat_t  stat_i,
  input  wire [31:0]            hash_word_i
);
  import sha256_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic        fin_q, fin_d;
  logic [3:0]  pad_q, pad_d;       // 0: 0x80, 1: zeros, 2..9: length bytes
  logic [2:0]  idx_q, idx_d;
  logic        ovld_q, ovld_d;
  logic [31:0] oword_q, oword_d;
  logic [2:0]  oidx_q;
  logic [63:0] bits;
  logic [2:0]  lsel;
  logic [7:0]  pbyte;
  logic        acc;
  logic        pushing;

  assign bits = {stat_i.byte_count[60:0], 3'b000};
  assign lsel = 3'(pad_q - 4'd2);
  assign acc  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle);

  // Pad byte for the current padding step
  always_comb begin
    case (pad_q)
      4'd0:    pbyte = 8'h80;
      4'd1:    pbyte = 8'h00;
      default: pbyte = bits[6'd63 - {lsel, 3'b000} -: 8];
    endcase
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    fin_d   = fin_q;
    pad_d   = pad_q;
    idx_d   = idx_q;
    ovld_d  = ovld_q;
    oword_d = oword_q;
    ctrl_o  = '{cmd: CMD_NONE, push_byte: in_if.data_byte, round: round_q, out_sel: idx_q};
    pushing = 1'b0;
    if (ovld_q && out_if.ready) ovld_d = 1'b0;
    unique case (state_q)
      StIdle: if (acc) begin
        fin_d = in_if.last;
        pad_d = 4'd0;
        if (in_if.has_byte) begin
          ctrl_o.cmd   = CMD_PUSH;
          ctrl_o.round = 6'd1;  // count this byte
          pushing = 1'b1;
        end else if (in_if.last) begin
          state_d = StPad;
        end
      end
      StPad: begin
        ctrl_o.cmd       = CMD_PUSH;
        ctrl_o.round     = 6'd0;
        ctrl_o.push_byte = pbyte;
        pushing = 1'b1;
        if (pad_q == 4'd0) pad_d = (stat_i.fill == 6'd55) ? 4'd2 : 4'd1;
        else if (pad_q == 4'd1) pad_d = (stat_i.fill == 6'd55) ? 4'd2 : 4'd1;
        else pad_d = pad_q + 4'd1;
      end
      StLoad: begin
        ctrl_o.cmd = CMD_LOAD;
        round_d = '0;
        state_d = StRound;
      end
      StRound: begin
        ctrl_o.cmd = CMD_ROUND;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) state_d = StAdd;
      end
      StAdd: begin
        ctrl_o.cmd = CMD_ADD;
        if (!fin_q) state_d = StIdle;
        else if (pad_q == 4'd10) begin
          state_d = StOut;
          idx_d = '0;
        end else state_d = StPad;
      end
      StOut: if (!ovld_q || out_if.ready) begin
        oword_d = hash_word_i;
        ovld_d  = 1'b1;
        idx_d   = idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          ctrl_o.cmd = CMD_INIT;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // Block full after this push: compress; a last input byte pushed in idle starts padding
    if (pushing) begin
      if (stat_i.fill == 6'd63) state_d = StLoad;
      else if (state_q == StPad && pad_q == 4'd9) state_d = StLoad;
      else if (state_q == StIdle && in_if.last) state_d = StPad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      fin_q   <= 1'b0;
      pad_q   <= '0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      fin_q   <= fin_d;
      pad_q   <= pad_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  // Output payload registers
  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    if (state_q == StOut && (!ovld_q || out_if.ready)) oidx_q <= idx_q;
  end

  assign out_if.valid       = ovld_q;
  assign out_if.digest_word = oword_q;
  assign out_if.word_index  = oidx_q;
  assign out_if.last_word   = (oidx_q == 3'd7);

  // Hold a pending result under back-pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !out_if.ready |=> ovld_q && $stable(oword_q))
    else $error("pending digest word lost");
  // No input while the block works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> !in_if.ready)
    else $error("input accepted during compression");
  // Compression starts only on a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> stat_i.fill == 6'd0)
    else $error("compression on partial block");

endmodule
`default_nettype wire

// File: src/sha256_message_digest.sv
// SHA-256 top level: joins controller and datapath.
// Depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_dp.
//
//  channel | dir | payload                              | handshake
//  in_if   | in  | data_byte[8], has_byte, last         | valid/ready
//  out_if  | out | digest_word[32], word_index[3], last_word | valid/ready
//
// Bytes are accepted back to back while idle; every 64th byte starts a compression
// (load, 64 rounds on one round unit, hash add). A last item adds padding pushes,
// one or two compressions and 8 digest words out. Input is refused during all
// of that. Reset is asynchronous and loads the initial hash. Output stalls hold
// the current word.
`default_nettype none
module sha256_message_digest (
  input  wire          clk_i,
  input  wire          rst_ni,
  sha256_in_if.sink    in_if,
  sha256_out_if.source out_if
);
  import sha256_pkg::*;

  dp_ctrl_t    ctrl;
  dp_stat_t    stat;
  logic [31:0] hword;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .ctrl_o(ctrl), .stat_i(stat), .hash_word_i(hword)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .hash_word_o(hword)
  );

endmodule
`default_nettype wire

// File: bench/tb_sha256_message_digest.sv
// Self-checking testbench for sha256_message_digest: byte stream in, digest words out.
// Depends on sha256_pkg, sha256_if and the block itself.
`timescale 1ns / 1ps

class digest_scoreboard;
  logic [31:0] hash_st [8];
  logic [31:0] sched [16];
  logic [63:0] byte_cnt;
  logic [5:0]  fill;
  logic [31:0] exp_word [$];
  logic [2:0]  exp_idx [$];
  logic        exp_lastw [$];
  int          errors;

  function new();
    restart();
    byte_cnt = '0;
    fill     = '0;
    errors   = 0;
  endfunction

  function void restart();
    hash_st = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function logic [31:0] kconst(int r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  // Run 64 rounds over the block buffer, rolling the schedule in place
  function void compress();
    logic [31:0] v [8];
    logic [31:0] w, x15, x2, e, a, t1, t2;
    v = hash_st;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        x15 = sched[(r - 15) & 15];
        x2  = sched[(r - 2) & 15];
        w = sched[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
          + sched[(r - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        sched[r & 15] = w;
      end
      e = v[4];
      a = v[0];
      t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + kconst(r) + w;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  function void pack_byte(logic [7:0] b);
    if (fill[1:0] == 2'd0) sched[fill[5:2]] = '0;
    sched[fill[5:2]] |= 32'(b) << (24 - 8 * fill[1:0]);
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endfunction

  // Note one accepted input transaction
  function void note_input(logic [7:0] d, logic hb, logic lst);
    logic [63:0] bits;
    if (hb) begin
      byte_cnt = byte_cnt + 64'd1;
      pack_byte(d);
    end
    if (!lst) return;
    bits = byte_cnt << 3;
    pack_byte(8'h80);
    while (fill != 6'd56) pack_byte(8'h00);
    for (int i = 0; i < 8; i++) pack_byte(bits[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) begin
      exp_word  = {exp_word, hash_st[i]};
      exp_idx   = {exp_idx, 3'(i)};
      exp_lastw = {exp_lastw, (i == 7)};
    end
    restart();
    byte_cnt = '0;
    fill     = '0;
  endfunction

  // Check one accepted output transaction against the oldest expected word
  function void check_word(logic [31:0] w, logic [2:0] idx, logic lw);
    logic [31:0] ew;
    logic [2:0]  ei;
    logic        el;
    if (exp_word.size() == 0) begin
      $display("%0t: unexpected digest word %h idx %0d", $time, w, idx);
      errors++;
      return;
    end
    ew = exp_word.pop_front();
    ei = exp_idx.pop_front();
    el = exp_lastw.pop_front();
    if (w !== ew) begin
      $display("%0t: digest_word expected %h actual %h", $time, ew, w);
      errors++;
    end
    if (idx !== ei) begin
      $display("%0t: word_index expected %0d actual %0d", $time, ei, idx);
      errors++;
    end
    if (lw !== el) begin
      $display("%0t: last_word expected %b actual %b", $time, el, lw);
      errors++;
    end
  endfunction

  function int pending();
    return exp_word.size();
  endfunction
endclass

module tb_sha256_message_digest;
  localparam int WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_message_digest dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  digest_scoreboard sb;
  int  idle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Observe both channels and keep the watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cnt <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.data_byte, in_if.has_byte, in_if.last);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stall before each word, with stretches of none
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_item(logic [7:0] d, logic hb, logic lst, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.has_byte  <= hb;
    in_if.last      <= lst;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Send a whole message of random bytes, sometimes with idle and ignored-data items
  task automatic send_message(int len, bit fin_has, bit burst);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, burst);
      send_item(8'($urandom), 1'b1, (i == len - 1) && fin_has, burst);
    end
    if (!fin_has || len == 0) send_item(8'($urandom), 1'b0, 1'b1, burst);
  endtask

  initial begin
    int len;
    sb = new();
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.has_byte  = 1'b0;
    in_if.last      = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, extreme bytes, ignored data, idle items
    send_item(8'hff, 1'b0, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0, 1'b1);
    send_item(8'h62, 1'b1, 1'b0, 1'b1);
    send_item(8'h63, 1'b1, 1'b1, 1'b1);
    send_item(8'haa, 1'b0, 1'b1, 1'b0);
    // Lengths at the padding boundary: 55 fits one block, 56 needs two
    send_message(55, 1'b1, 1'b0);
    send_message(56, 1'b0, 1'b1);
    send_message(64, 1'b1, 1'b0);

    // A few short random messages
    for (int m = 0; m < 3; m++) begin
      len = $urandom_range(0, 4);
      send_message(len, 1'($urandom), ($urandom_range(0, 3) == 0));
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_dp.sv
src/sha256_ctrl.sv
src/sha256_message_digest.sv
bench/tb_sha256_message_digest.sv
